// ----- hdl/wipbt_pkg.sv -----
// Package for the wildcard IP ban table: item types, table entry layout,
// state and status codes, and the pattern normalizing function. No dependencies.
package wipbt_pkg;

	localparam int TABLE_DEPTH_DEFAULT = 256;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR     = 3'd0,
		ST_BANNED    = 3'd1,
		ST_ADDED     = 3'd2,
		ST_FULL      = 3'd3,
		ST_DUPLICATE = 3'd4,
		ST_REMOVED   = 3'd5,
		ST_NOTFOUND  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_APPEND,
		S_DONE
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  octet_a;
		logic [7:0]  octet_b;
		logic [7:0]  octet_c;
		logic [7:0]  octet_d;
		logic [3:0]  wildcard_bits;
		logic [31:0] now_seconds;
		logic [30:0] ban_seconds;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  match_index;
		logic [8:0]  entry_count;
		logic [8:0]  expired_removed;
	} out_item_t;

	// Wildcard bit 0 covers octet a, bit 3 covers octet d.
	typedef struct packed {
		logic [3:0] wild;
		logic [7:0] oct_a;
		logic [7:0] oct_b;
		logic [7:0] oct_c;
		logic [7:0] oct_d;
	} pattern_t;

	typedef struct packed {
		pattern_t    pat;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic expired;
		logic addr_hit;
		logic identical;
	} eval_t;

	// Octets under a wildcard bit are stored as zero, so identical patterns
	// compare equal over all their bits.
	function automatic pattern_t make_pattern(in_item_t it);
		pattern_t p;
		p.wild  = it.wildcard_bits;
		p.oct_a = it.wildcard_bits[0] ? 8'd0 : it.octet_a;
		p.oct_b = it.wildcard_bits[1] ? 8'd0 : it.octet_b;
		p.oct_c = it.wildcard_bits[2] ? 8'd0 : it.octet_c;
		p.oct_d = it.wildcard_bits[3] ? 8'd0 : it.octet_d;
		return p;
	endfunction

endpackage

// ----- hdl/wildcard_ip_ban_table.sv -----
// Top level of the wildcard IP ban table: command sequencer, table memory and
// entry evaluation. Depends on wipbt_pkg, wipbt_ram and wipbt_eval.
//
// The block keeps an ordered, gap-free table of up to TABLE_DEPTH IPv4 ban
// patterns in one synchronous memory. An item is taken when start is high and
// busy is low; busy then stays high until the result has been shown. The
// result appears on result for exactly one cycle with result_strobe high, and
// the receiver cannot stall it, so it must capture the result in that cycle.
// Every operation walks the table one entry at a time: a read step (S_READ) and
// an evaluate/write-back step (S_EVAL) per entry on the memory port. An add then
// appends the new entry (S_APPEND) unless it stops early on a duplicate; an add
// to a full table or an unused kind goes straight to the result (S_DONE). A
// lookup drops expired entries and a remove drops the first identical pattern
// while the walk compacts later entries downward in place. The memory needs
// no clearing after reset: only entries below the entry count are ever read.
module wildcard_ip_ban_table import wipbt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      result_strobe,
	output out_item_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	state_t state_q, state_d;

	in_item_t      cmd_q;
	logic [CW-1:0] count_q;   // entries in the table
	logic [CW-1:0] rd_q;      // next entry to read
	logic [CW-1:0] wr_q;      // next compacted position
	logic [CW-1:0] expired_q;
	logic [CW-1:0] match_q;
	logic          found_q;
	logic          full_q;

	entry_t rdata;
	eval_t  ev;

	// Memory write port.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;

	logic          drop;
	logic          last;
	logic [CW-1:0] rd_next;
	logic [CW-1:0] wr_next;
	entry_t        new_entry;
	logic [32:0]   exp_sum;
	logic          accept;

	assign accept = start && !busy;

	wipbt_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (state_q == S_READ),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	wipbt_eval u_eval (
		.entry(rdata),
		.cmd  (cmd_q),
		.res  (ev)
	);

	// An entry leaves the table when a lookup finds it expired, or when it is
	// the first pattern identical to the one being removed.
	assign drop = ((cmd_q.kind == KIND_LOOKUP) && ev.expired) ||
		((cmd_q.kind == KIND_REMOVE) && !found_q && ev.identical);
	assign rd_next = rd_q + 1'b1;
	assign wr_next = wr_q + CW'(!drop);
	assign last    = (rd_next == count_q);

	// New entry for an add: zero duration means permanent, otherwise the
	// expiry saturates at the top of the 32-bit range.
	assign exp_sum       = {1'b0, cmd_q.now_seconds} + {2'b00, cmd_q.ban_seconds};
	assign new_entry.pat = make_pattern(cmd_q);
	assign new_entry.expiry = (cmd_q.ban_seconds == 31'd0) ? 32'd0 :
		(exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0]);

	// Writes always land at or below the entry being evaluated, and the next
	// read is strictly above it, so a read never meets a pending write.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q[AW-1:0];
		mem_wdata = rdata;
		if (state_q == S_EVAL) begin
			mem_we = (cmd_q.kind != KIND_ADD) && !drop && (wr_q != rd_q);
		end else if (state_q == S_APPEND) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[AW-1:0];
			mem_wdata = new_entry;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.kind == KIND_NOP) begin
						state_d = S_DONE;
					end else if (item.kind == KIND_ADD && count_q == FULL_COUNT) begin
						state_d = S_DONE;
					end else if (count_q == '0) begin
						state_d = (item.kind == KIND_ADD) ? S_APPEND : S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (cmd_q.kind == KIND_ADD && ev.identical) begin
					state_d = S_DONE;
				end else if (last) begin
					state_d = (cmd_q.kind == KIND_ADD) ? S_APPEND : S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_APPEND: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			expired_q <= '0;
			match_q   <= '0;
			found_q   <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_q      <= '0;
						wr_q      <= '0;
						expired_q <= '0;
						match_q   <= '0;
						found_q   <= 1'b0;
						full_q    <= (count_q == FULL_COUNT);
					end
				end
				S_EVAL: begin
					rd_q <= rd_next;
					wr_q <= wr_next;
					if (cmd_q.kind == KIND_LOOKUP) begin
						if (drop) begin
							expired_q <= expired_q + 1'b1;
						end else if (ev.addr_hit && !found_q) begin
							found_q <= 1'b1;
							match_q <= wr_q;
						end
					end else if (cmd_q.kind == KIND_REMOVE) begin
						if (drop) begin
							found_q <= 1'b1;
						end
					end else if (ev.identical) begin
						found_q <= 1'b1;
					end
					if (last) begin
						count_q <= wr_next;
					end
				end
				S_APPEND: begin
					count_q <= count_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item;
		end
	end

	// Outputs.
	logic [31:0] count_w;
	logic [31:0] match_w;
	logic [31:0] expired_w;
	status_t     status_d;

	assign count_w   = 32'(count_q);
	assign match_w   = 32'(match_q);
	assign expired_w = 32'(expired_q);

	always_comb begin
		status_d = ST_CLEAR;
		case (cmd_q.kind)
			KIND_LOOKUP: status_d = found_q ? ST_BANNED : ST_CLEAR;
			KIND_ADD:    status_d = full_q ? ST_FULL :
				(found_q ? ST_DUPLICATE : ST_ADDED);
			KIND_REMOVE: status_d = found_q ? ST_REMOVED : ST_NOTFOUND;
			default:     status_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy                   = (state_q != S_IDLE);
		result_strobe          = (state_q == S_DONE);
		result.status          = status_d;
		result.match_index     = match_w[7:0];
		result.entry_count     = count_w[8:0];
		result.expired_removed = expired_w[8:0];
	end

`ifndef SYNTHESIS
	// The table never holds more entries than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count exceeds table depth");

	// An accepted item always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start an operation");

	// Busy ends only right after the result has been shown.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_strobe))
		else $error("operation ended without a result");

	// Each item yields a single one-cycle result.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("result strobe held for more than one cycle");
`endif

endmodule

// ----- hdl/wipbt_ram.sv -----
// Table storage for the wildcard IP ban table: one write port, one read port,
// registered read data. Depends on wipbt_pkg.
module wipbt_ram import wipbt_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// ----- hdl/wipbt_eval.sv -----
// Entry evaluation for the wildcard IP ban table: expiry test, wildcard
// address match and exact pattern compare of one stored entry. Depends on wipbt_pkg.
module wipbt_eval import wipbt_pkg::*; (
	input  entry_t   entry,
	input  in_item_t cmd,
	output eval_t    res
);

	pattern_t want;
	logic [3:0] oct_ok;

	assign want = make_pattern(cmd);

	assign oct_ok[0] = entry.pat.wild[0] || (entry.pat.oct_a == cmd.octet_a);
	assign oct_ok[1] = entry.pat.wild[1] || (entry.pat.oct_b == cmd.octet_b);
	assign oct_ok[2] = entry.pat.wild[2] || (entry.pat.oct_c == cmd.octet_c);
	assign oct_ok[3] = entry.pat.wild[3] || (entry.pat.oct_d == cmd.octet_d);

	assign res.expired   = (entry.expiry != 32'd0) && (cmd.now_seconds > entry.expiry);
	assign res.addr_hit  = &oct_ok;
	assign res.identical = (entry.pat == want);

endmodule
